// File: rtl/ecpm_pkg.sv
package ecpm_pkg;

    localparam int LIMIT_W    = 16;
    localparam int COLOR_W    = 24;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MODE_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIN_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_A    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_B    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_C    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRIPE_EVN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STRIPE_ODD = 3'd7;

    localparam logic [MODE_W-1:0] MODE_PROP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STRIPE = 2'd2;

    localparam logic [LIMIT_W-1:0] RST_LIMIT      = 16'd1000;
    localparam logic [MODE_W-1:0]  RST_MODE       = MODE_PROP;
    localparam logic [COLOR_W-1:0] RST_COLOR_A    = 24'h000040;
    localparam logic [COLOR_W-1:0] RST_COLOR_B    = 24'hFFFF00;
    localparam logic [COLOR_W-1:0] RST_COLOR_C    = 24'hFF0000;
    localparam logic [COLOR_W-1:0] RST_STRIPE_EVN = 24'h000040;
    localparam logic [COLOR_W-1:0] RST_STRIPE_ODD = 24'hFFFFFF;

    typedef enum logic [1:0] {
        KIND_GRAD,
        KIND_BLACK,
        KIND_EVEN,
        KIND_ODD
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  in_set;
    } t_tag;

endpackage

// File: rtl/ecpm_div.sv
module ecpm_div
    import ecpm_pkg::*;
#(
    parameter int NUM_ANCHORS   = 3,
    parameter int SEGMENT_STEPS = 128
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_vld,
    output logic                                          o_rdy,
    input  logic [LIMIT_W+$clog2((NUM_ANCHORS-1)*SEGMENT_STEPS)-1:0] i_num,
    input  logic [LIMIT_W-1:0]                            i_div,
    input  logic                                          i_clamp,
    input  t_tag                                          i_tag,
    output logic                                          o_vld,
    input  logic                                          i_rdy,
    output logic [$clog2((NUM_ANCHORS-1)*SEGMENT_STEPS)-1:0] o_k,
    output t_tag                                          o_tag
);

    localparam int ENTRIES = (NUM_ANCHORS - 1) * SEGMENT_STEPS;
    localparam int KW      = $clog2(ENTRIES);
    localparam int NW      = LIMIT_W + KW;

    // one quotient bit per stage: remainder in the upper bits, quotient shifts in below
    function automatic logic [NW-1:0] div_step(input logic [NW-1:0] acc,
                                               input logic [LIMIT_W-1:0] dv);
        logic [LIMIT_W:0]   t;
        logic               ge;
        logic [LIMIT_W:0]   rem;
        t   = {acc[NW-1 -: LIMIT_W], acc[KW-1]};
        ge  = t >= {1'b0, dv};
        rem = ge ? (t - {1'b0, dv}) : t;
        return {rem[LIMIT_W-1:0], acc[KW-2:0], ge};
    endfunction

    logic [NW-1:0]      r_acc   [KW];
    logic [LIMIT_W-1:0] r_div   [KW];
    logic               r_clamp [KW];
    t_tag               r_tag   [KW];
    logic               r_vld   [KW];
    logic               stg_en  [KW];

    always_comb begin
        stg_en[KW-1] = !r_vld[KW-1] || i_rdy;
        for (int j = KW - 2; j >= 0; j--) begin
            stg_en[j] = !r_vld[j] || stg_en[j+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < KW; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int j = 1; j < KW; j++) begin
                if (stg_en[j]) begin
                    r_vld[j] <= r_vld[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_acc[0]   <= div_step(i_num, i_div);
            r_div[0]   <= i_div;
            r_clamp[0] <= i_clamp;
            r_tag[0]   <= i_tag;
        end
        for (int j = 1; j < KW; j++) begin
            if (stg_en[j]) begin
                r_acc[j]   <= div_step(r_acc[j-1], r_div[j-1]);
                r_div[j]   <= r_div[j-1];
                r_clamp[j] <= r_clamp[j-1];
                r_tag[j]   <= r_tag[j-1];
            end
        end
    end

    assign o_rdy = stg_en[0];
    assign o_vld = r_vld[KW-1];
    assign o_tag = r_tag[KW-1];
    assign o_k   = r_clamp[KW-1] ? KW'(ENTRIES - 1) : r_acc[KW-1][KW-1:0];

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[KW-1] && !r_clamp[KW-1]
        |-> {1'b0, r_acc[KW-1][KW-1:0]} < (KW+1)'(ENTRIES))
        else $error("quotient beyond gradient");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[KW-1] && !r_clamp[KW-1]
        |-> r_acc[KW-1][NW-1 -: LIMIT_W] < r_div[KW-1])
        else $error("remainder not below divisor");

endmodule

// File: rtl/ecpm_blend.sv
module ecpm_blend
    import ecpm_pkg::*;
#(
    parameter int NUM_ANCHORS   = 3,
    parameter int SEGMENT_STEPS = 128
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_vld,
    output logic                                             o_rdy,
    input  logic [$clog2((NUM_ANCHORS-1)*SEGMENT_STEPS)-1:0] i_k,
    input  t_tag                                             i_tag,
    input  logic [COLOR_W-1:0]                               i_color_a,
    input  logic [COLOR_W-1:0]                               i_color_b,
    input  logic [COLOR_W-1:0]                               i_color_c,
    output logic                                             o_vld,
    input  logic                                             i_rdy,
    output logic [COLOR_W-1:0]                               o_rgb,
    output t_tag                                             o_tag
);

    localparam int ENTRIES = (NUM_ANCHORS - 1) * SEGMENT_STEPS;
    localparam int KW      = $clog2(ENTRIES);
    localparam int PW      = $clog2(SEGMENT_STEPS);
    localparam int SPAN    = SEGMENT_STEPS - 1;
    localparam int PRW     = CH_W + PW;
    localparam int XW      = PRW + 1;
    localparam int NCH     = COLOR_W / CH_W;
    localparam int NSTG    = 6;
    localparam logic [XW:0] RECIP = (XW+1)'((64'd1 << XW) / SPAN);

    logic r_vld  [NSTG];
    logic stg_en [NSTG];
    t_tag r_tag  [NSTG];

    // stage 1: segment and position
    logic [COLOR_W-1:0] r1_ca, r1_cb;
    logic [PW-1:0]      r1_p, r1_wp;
    // stage 2: weighted anchors
    logic [PRW-1:0]     r2_pa [NCH];
    logic [PRW-1:0]     r2_pb [NCH];
    // stage 3: blend sum
    logic [XW-1:0]      r3_x  [NCH];
    // stage 4: quotient estimate
    logic [XW-1:0]      r4_x  [NCH];
    logic [CH_W-1:0]    r4_q  [NCH];
    // stage 5: remainder
    logic [XW-1:0]      r5_r  [NCH];
    logic [CH_W-1:0]    r5_q  [NCH];
    // stage 6: corrected channel
    logic [CH_W-1:0]    r6_q  [NCH];

    logic               n_seg;
    logic [PW-1:0]      n_p;
    logic [2*XW:0]      n_prod [NCH];

    always_comb begin
        n_seg = {1'b0, i_k} >= (KW+1)'(SEGMENT_STEPS);
        n_p   = n_seg ? PW'({1'b0, i_k} - (KW+1)'(SEGMENT_STEPS)) : PW'(i_k);
        for (int c = 0; c < NCH; c++) begin
            n_prod[c] = (2*XW+1)'(r3_x[c]) * (2*XW+1)'(RECIP);
        end
    end

    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || i_rdy;
        for (int j = NSTG - 2; j >= 0; j--) begin
            stg_en[j] = !r_vld[j] || stg_en[j+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NSTG; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int j = 1; j < NSTG; j++) begin
                if (stg_en[j]) begin
                    r_vld[j] <= r_vld[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_tag[0] <= i_tag;
            r1_ca    <= n_seg ? i_color_b : i_color_a;
            r1_cb    <= n_seg ? i_color_c : i_color_b;
            r1_p     <= n_p;
            r1_wp    <= PW'(SPAN) - n_p;
        end
        for (int j = 1; j < NSTG; j++) begin
            if (stg_en[j]) begin
                r_tag[j] <= r_tag[j-1];
            end
        end
        for (int c = 0; c < NCH; c++) begin
            if (stg_en[1]) begin
                r2_pa[c] <= PRW'(r1_ca[c*CH_W +: CH_W]) * PRW'(r1_wp);
                r2_pb[c] <= PRW'(r1_cb[c*CH_W +: CH_W]) * PRW'(r1_p);
            end
            if (stg_en[2]) begin
                r3_x[c] <= XW'(r2_pa[c]) + XW'(r2_pb[c]);
            end
            if (stg_en[3]) begin
                r4_x[c] <= r3_x[c];
                r4_q[c] <= n_prod[c][XW +: CH_W];
            end
            if (stg_en[4]) begin
                r5_r[c] <= r4_x[c] - XW'(XW'(r4_q[c]) * XW'(SPAN));
                r5_q[c] <= r4_q[c];
            end
            if (stg_en[5]) begin
                r6_q[c] <= r5_q[c] + CH_W'(r5_r[c] >= XW'(SPAN));
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            o_rgb[c*CH_W +: CH_W] = r6_q[c];
        end
    end

    assign o_rdy = stg_en[0];
    assign o_vld = r_vld[NSTG-1];
    assign o_tag = r_tag[NSTG-1];

    // reciprocal estimate is at most one short
    a_one_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r5_r[0] < (XW)'(2 * SPAN)) && (r5_r[1] < (XW)'(2 * SPAN))
                     && (r5_r[2] < (XW)'(2 * SPAN)))
        else $error("blend remainder needs more than one correction");

endmodule

// File: rtl/escape_count_palette_mapper_core.sv
// Pipeline from input request to output request: front stage, one divide stage per
//   index bit, six blend stages, output register.
// Throughput: one pixel per cycle while not stalled; stalls propagate stage by stage
//   and fill bubbles.
// Reset (i_rst_n low, synchronous): pipeline emptied, config registers back to defaults.
module escape_count_palette_mapper_core
    import ecpm_pkg::*;
#(
    parameter int NUM_ANCHORS   = 3,
    parameter int SEGMENT_STEPS = 128,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]               i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [COUNT_WIDTH-1:0] iteration_count
    input  logic [((COUNT_WIDTH+7)/8)*8-1:0]    i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [24] in_set
    output logic [31:0]                         o_m_tdata
);

    localparam int ENTRIES = (NUM_ANCHORS - 1) * SEGMENT_STEPS;
    localparam int KW      = $clog2(ENTRIES);
    localparam int NW      = LIMIT_W + KW;
    localparam int CMPW    = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic [LIMIT_W-1:0] r_max_iter, r_lin_limit;
    logic [MODE_W-1:0]  r_mode;
    logic [COLOR_W-1:0] r_color_a, r_color_b, r_color_c, r_stripe_evn, r_stripe_odd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter   <= RST_LIMIT;
            r_mode       <= RST_MODE;
            r_lin_limit  <= RST_LIMIT;
            r_color_a    <= RST_COLOR_A;
            r_color_b    <= RST_COLOR_B;
            r_color_c    <= RST_COLOR_C;
            r_stripe_evn <= RST_STRIPE_EVN;
            r_stripe_odd <= RST_STRIPE_ODD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAX_ITER:   r_max_iter   <= i_cfg_data[LIMIT_W-1:0];
                REG_MODE:       r_mode       <= i_cfg_data[MODE_W-1:0];
                REG_LIN_LIMIT:  r_lin_limit  <= i_cfg_data[LIMIT_W-1:0];
                REG_COLOR_A:    r_color_a    <= i_cfg_data[COLOR_W-1:0];
                REG_COLOR_B:    r_color_b    <= i_cfg_data[COLOR_W-1:0];
                REG_COLOR_C:    r_color_c    <= i_cfg_data[COLOR_W-1:0];
                REG_STRIPE_EVN: r_stripe_evn <= i_cfg_data[COLOR_W-1:0];
                REG_STRIPE_ODD: r_stripe_odd <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // front stage: classify, pick divisor, scale count
    logic [CMPW-1:0]    n_count;
    logic [LIMIT_W-1:0] n_div;
    logic               n_clamp;
    logic [NW-1:0]      n_num;
    t_tag               n_tag;

    always_comb begin
        n_count = CMPW'(i_s_tdata[COUNT_WIDTH-1:0]);
        n_div   = (r_mode == MODE_LINEAR) ? r_lin_limit : r_max_iter;
        n_clamp = n_count >= CMPW'(n_div);
        n_num   = NW'(n_count[LIMIT_W-1:0]) * NW'(ENTRIES);
        n_tag.in_set = n_count == CMPW'(r_max_iter);
        if (n_tag.in_set) begin
            n_tag.kind = KIND_BLACK;
        end else begin
            unique case (r_mode)
                MODE_PROP, MODE_LINEAR: n_tag.kind = KIND_GRAD;
                MODE_STRIPE:            n_tag.kind = n_count[0] ? KIND_ODD : KIND_EVEN;
                default:                n_tag.kind = KIND_BLACK;
            endcase
        end
    end

    logic               r_f_vld;
    logic [LIMIT_W-1:0] r_f_div;
    logic               r_f_clamp;
    logic [NW-1:0]      r_f_num;
    t_tag               r_f_tag;
    logic               f_en;
    logic               div_rdy;

    assign f_en       = !r_f_vld || div_rdy;
    assign o_s_tready = f_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (f_en) begin
            r_f_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_f_div   <= n_div;
            r_f_clamp <= n_clamp;
            r_f_num   <= n_num;
            r_f_tag   <= n_tag;
        end
    end

    logic               div_vld;
    logic [KW-1:0]      div_k;
    t_tag               div_tag;
    logic               bl_rdy;

    ecpm_div #(
        .NUM_ANCHORS   (NUM_ANCHORS),
        .SEGMENT_STEPS (SEGMENT_STEPS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_f_vld),
        .o_rdy   (div_rdy),
        .i_num   (r_f_num),
        .i_div   (r_f_div),
        .i_clamp (r_f_clamp),
        .i_tag   (r_f_tag),
        .o_vld   (div_vld),
        .i_rdy   (bl_rdy),
        .o_k     (div_k),
        .o_tag   (div_tag)
    );

    logic               bl_vld;
    logic [COLOR_W-1:0] bl_rgb;
    t_tag               bl_tag;
    logic               o_en;

    ecpm_blend #(
        .NUM_ANCHORS   (NUM_ANCHORS),
        .SEGMENT_STEPS (SEGMENT_STEPS)
    ) u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (div_vld),
        .o_rdy     (bl_rdy),
        .i_k       (div_k),
        .i_tag     (div_tag),
        .i_color_a (r_color_a),
        .i_color_b (r_color_b),
        .i_color_c (r_color_c),
        .o_vld     (bl_vld),
        .i_rdy     (o_en),
        .o_rgb     (bl_rgb),
        .o_tag     (bl_tag)
    );

    // output register
    logic [COLOR_W-1:0] n_rgb;
    logic               r_o_vld;
    logic [COLOR_W-1:0] r_o_rgb;
    logic               r_o_in_set;

    always_comb begin
        unique case (bl_tag.kind)
            KIND_GRAD:  n_rgb = bl_rgb;
            KIND_EVEN:  n_rgb = r_stripe_evn;
            KIND_ODD:   n_rgb = r_stripe_odd;
            KIND_BLACK: n_rgb = '0;
            default:    n_rgb = '0;
        endcase
    end

    assign o_en = !r_o_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (o_en) begin
            r_o_vld <= bl_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_o_rgb    <= n_rgb;
            r_o_in_set <= bl_tag.in_set;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {7'd0, r_o_in_set, r_o_rgb[7:0], r_o_rgb[15:8], r_o_rgb[23:16]};

    a_in_set_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[24] |-> o_m_tdata[23:0] == 24'd0)
        else $error("in-set pixel not black");

    a_front_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_f_vld)
        else $error("accepted request missing in front stage");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !r_f_vld)
        else $error("pipeline not empty after reset");

endmodule
